>>> hdl/ttc_eb_pkg.sv
`default_nettype none

package ttc_eb_pkg;

    // Field widths.
    localparam int ANGLE_W   = 16;
    localparam int STEP_W    = 12;
    localparam int LIMIT_W   = 14;
    localparam int SPEED_W   = 16;
    localparam int RANGE_W   = 16;
    localparam int RAY_W     = 11;
    localparam int ALONG_W   = 15;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_START  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TTC_LIMIT_MS = 2'd2;

    // Register reset values.
    localparam logic [ANGLE_W-1:0] ANGLE_START_RST = 16'hA000;
    localparam logic [STEP_W-1:0]  ANGLE_STEP_RST  = 12'd48;
    localparam logic [LIMIT_W-1:0] TTC_LIMIT_RST   = 14'd2000;

    // Scan geometry.
    localparam int MAX_RAYS = 2048;
    localparam logic [RAY_W-1:0] RAY_LAST = RAY_W'(MAX_RAYS - 1);

    // Range is scaled to mm*ms/s so that the threshold test needs no divider.
    localparam int RANGE_K_W = 26;
    localparam logic [9:0] RANGE_SCALE = 10'd1000;
    localparam int PROD_W = 32;
    localparam int RHS_W  = LIMIT_W + ALONG_W;

    // Quarter-wave cosine table, Q0.15 magnitudes.
    localparam int COS_ENTRIES = 256;
    localparam int COS_IDX_W   = $clog2(COS_ENTRIES);
    localparam int COS_W       = 15;
    localparam int QUAD_R_W    = ANGLE_W - 2;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;
    localparam logic [63:0] COS_FULL    = 64'd32767;
    localparam logic [63:0] ROUND_Q30   = 64'd536870912;

    typedef logic [63:0] taylor_div_t [7];
    localparam taylor_div_t TAYLOR_DIV = '{64'd2, 64'd12, 64'd30, 64'd56,
                                           64'd90, 64'd132, 64'd182};

    typedef logic [COS_W-1:0] cos_rom_t [COS_ENTRIES];

    // Builds the table at elaboration: Taylor series to x^14 in Q30.
    function automatic cos_rom_t build_cos_rom();
        cos_rom_t           rom;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        scaled;
        for (int k = 0; k < COS_ENTRIES; k++)
        begin
            x    = (HALF_PI_Q30 * 64'(k)) / COS_ENTRIES;
            x2   = (x * x) >> 30;
            term = ONE_Q30;
            sum  = $signed(ONE_Q30);
            for (int n = 1; n <= 7; n++)
            begin
                term = (term * x2) / TAYLOR_DIV[n-1];
                term = term >> 30;
                if ((n % 2) == 1)
                begin
                    sum = sum - $signed(term);
                end
                else
                begin
                    sum = sum + $signed(term);
                end
            end
            if (sum < 0)
            begin
                sum = '0;
            end
            if (sum > $signed(ONE_Q30))
            begin
                sum = $signed(ONE_Q30);
            end
            scaled = ($unsigned(sum) * COS_FULL + ROUND_Q30) >> 30;
            rom[k] = scaled[COS_W-1:0];
        end
        return rom;
    endfunction

    localparam cos_rom_t COS_ROM = build_cos_rom();

    // State memory layout: one entry for the speed, one for the scan.
    localparam int MEM_DEPTH  = 2;
    localparam int MEM_ADDR_W = 1;
    localparam logic [MEM_ADDR_W-1:0] ADDR_SPEED = 1'b0;
    localparam logic [MEM_ADDR_W-1:0] ADDR_SCAN  = 1'b1;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic [RAY_W-1:0]   count;
        logic               braked;
    } scan_rec_t;

    localparam int MEM_W = $bits(scan_rec_t);

endpackage

`default_nettype wire

>>> hdl/ttc_eb_if.sv
`default_nettype none

// Input word: a speed update or one lidar range sample.
interface ttc_eb_item_if
    import ttc_eb_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic                      func;
    logic signed [SPEED_W-1:0] speed_mm_s;
    logic [RANGE_W-1:0]        range_mm;
    logic                      first_ray;

    modport source (output valid, func, speed_mm_s, range_mm, first_ray, input ready);
    modport sink (input valid, func, speed_mm_s, range_mm, first_ray, output ready);
endinterface

// Output word: one brake command.
interface ttc_eb_result_if
    import ttc_eb_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [RAY_W-1:0]   ray_index;
    logic [ALONG_W-1:0] along_speed;
    logic               drive_speed;

    modport source (output valid, ray_index, along_speed, drive_speed, input ready);
    modport sink (input valid, ray_index, along_speed, drive_speed, output ready);
endinterface

`default_nettype wire

>>> hdl/ttc_emergency_brake.sv
`default_nettype none

// Channel   Dir  Handshake     Payload
// item      in   valid/ready   func, speed_mm_s, range_mm, first_ray
// result    out  valid/ready   ray_index, along_speed, drive_speed
// cfg       in   cfg_we        cfg_index, cfg_data
//
// A speed word is written straight into the state RAM when it is taken.
// A ray word takes two RAM reads (speed, then scan record, with the cosine
// lookup beside it), the speed-by-cosine multiply, and the threshold multiply
// and compare, which also writes the scan record back.
// Reset clears the RAM valid bits, so both entries read as zero until written.
// A new word is taken while a brake word waits at the output; only a second
// brake word stalls, in the compare cycle, until the first one is taken.

module ttc_emergency_brake
    import ttc_eb_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    ttc_eb_item_if.sink               item,
    ttc_eb_result_if.source           result
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SPEED = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_CMP   = 3'd4;

    logic [2:0]                state_reg;
    logic [2:0]                state_next;
    logic [ANGLE_W-1:0]        angle_start_reg;
    logic [STEP_W-1:0]         angle_step_reg;
    logic [LIMIT_W-1:0]        ttc_limit_reg;
    logic [MEM_DEPTH-1:0]      mem_vld_reg;
    logic [RANGE_K_W-1:0]      range_k_reg;
    logic                      first_reg;
    logic signed [SPEED_W-1:0] speed_reg;
    scan_rec_t                 scan_reg;
    logic signed [COS_W:0]     cos_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic                      out_valid_reg;
    logic [RAY_W-1:0]          out_ray_reg;
    logic [ALONG_W-1:0]        out_along_reg;

    logic                      item_acc;
    logic                      spd_wr;
    logic                      scan_wr;
    logic                      mem_we;
    logic [MEM_ADDR_W-1:0]     mem_waddr;
    logic [MEM_W-1:0]          mem_wdata;
    logic [MEM_ADDR_W-1:0]     mem_raddr;
    logic [MEM_W-1:0]          mem_rdata;
    logic [RANGE_K_W-1:0]      range_k;
    scan_rec_t                 scan_old;
    scan_rec_t                 scan_new;
    logic [1:0]                quad;
    logic [QUAD_R_W-1:0]       quad_r;
    logic [QUAD_R_W:0]         quad_rev;
    logic [COS_IDX_W-1:0]      cos_idx;
    logic [COS_W-1:0]          cos_mag;
    logic signed [COS_W:0]     cos_val;
    logic                      prod_pos;
    logic [ALONG_W-1:0]        along;
    logic [RHS_W-1:0]          ttc_rhs;
    logic                      hit;
    logic                      cmp_done;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_start_reg <= ANGLE_START_RST;
            angle_step_reg  <= ANGLE_STEP_RST;
            ttc_limit_reg   <= TTC_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ANGLE_START:  angle_start_reg <= cfg_data[ANGLE_W-1:0];
                CFG_ANGLE_STEP:   angle_step_reg  <= cfg_data[STEP_W-1:0];
                CFG_TTC_LIMIT_MS: ttc_limit_reg   <= cfg_data[LIMIT_W-1:0];
                default:          ;
            endcase
        end
    end

    assign item.ready = (state_reg == ST_IDLE);
    assign item_acc   = item.valid && item.ready;
    assign range_k    = item.range_mm * RANGE_SCALE;

    // State RAM: speed words write at accept, ray words write back at compare.
    assign spd_wr    = item_acc && !item.func;
    assign scan_wr   = (state_reg == ST_CMP) && cmp_done;
    assign mem_we    = spd_wr || scan_wr;
    assign mem_waddr = spd_wr ? ADDR_SPEED : ADDR_SCAN;
    assign mem_wdata = spd_wr ? MEM_W'($unsigned(item.speed_mm_s)) : MEM_W'(scan_new);
    assign mem_raddr = (state_reg == ST_SPEED) ? ADDR_SCAN : ADDR_SPEED;

    ttc_eb_ram #(
        .WIDTH (MEM_W),
        .DEPTH (MEM_DEPTH)
    ) u_state_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Advance the scan record; a first ray restarts angle, count and latch.
    always_comb
    begin
        scan_old = mem_vld_reg[ADDR_SCAN] ? scan_rec_t'(mem_rdata) : '0;
        scan_new = scan_reg;
        if (state_reg == ST_CMP)
        begin
            scan_new.braked = scan_reg.braked || hit;
        end
        else if (first_reg)
        begin
            scan_new.angle  = angle_start_reg;
            scan_new.count  = '0;
            scan_new.braked = 1'b0;
        end
        else
        begin
            scan_new.angle  = scan_old.angle + ANGLE_W'(angle_step_reg);
            scan_new.count  = (scan_old.count == RAY_LAST) ? '0 : scan_old.count + 1'b1;
            scan_new.braked = scan_old.braked;
        end
    end

    // Quarter-wave cosine lookup; odd quadrants read the table backward.
    always_comb
    begin
        quad     = scan_new.angle[ANGLE_W-1 -: 2];
        quad_r   = scan_new.angle[QUAD_R_W-1:0];
        quad_rev = {1'b1, {QUAD_R_W{1'b0}}} - {1'b0, quad_r};
        if (quad[0])
        begin
            cos_idx = quad_rev[QUAD_R_W-1 -: COS_IDX_W];
            cos_mag = (quad_r == '0) ? '0 : COS_ROM[cos_idx];
        end
        else
        begin
            cos_idx = quad_r[QUAD_R_W-1 -: COS_IDX_W];
            cos_mag = COS_ROM[cos_idx];
        end
        if (quad == 2'd1 || quad == 2'd2)
        begin
            cos_val = -$signed({1'b0, cos_mag});
        end
        else
        begin
            cos_val = $signed({1'b0, cos_mag});
        end
    end

    // Threshold test: range*1000 < limit*along, only for a closing ray of an unbraked scan.
    assign prod_pos = (prod_reg > 0);
    assign along    = prod_pos ? prod_reg[PROD_W-3 -: ALONG_W] : '0;
    assign ttc_rhs  = ttc_limit_reg * along;
    assign hit      = !scan_reg.braked && (along != '0)
                      && (RHS_W'(range_k_reg) < ttc_rhs);
    assign cmp_done = !hit || !out_valid_reg || result.ready;

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (item_acc && item.func) state_next = ST_SPEED;
            ST_SPEED: state_next = ST_SCAN;
            ST_SCAN:  state_next = ST_MUL;
            ST_MUL:   state_next = ST_CMP;
            ST_CMP:   if (cmp_done) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            mem_vld_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (mem_we)
            begin
                mem_vld_reg[mem_waddr] <= 1'b1;
            end
        end
    end

    // Datapath registers along the ray sequence.
    always_ff @(posedge clk)
    begin
        if (item_acc)
        begin
            range_k_reg <= range_k;
            first_reg   <= item.first_ray;
        end
        if (state_reg == ST_SPEED)
        begin
            speed_reg <= mem_vld_reg[ADDR_SPEED] ? $signed(mem_rdata[SPEED_W-1:0]) : '0;
        end
        if (state_reg == ST_SCAN)
        begin
            scan_reg <= scan_new;
            cos_reg  <= cos_val;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= speed_reg * cos_reg;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (scan_wr && hit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_wr && hit)
        begin
            out_ray_reg   <= scan_reg.count;
            out_along_reg <= along;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.ray_index   = out_ray_reg;
    assign result.along_speed = out_along_reg;
    assign result.drive_speed = 1'b0;

    // A brake word appears only out of the compare cycle.
    a_out_from_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_CMP)
        else $error("brake word raised outside the compare cycle");

    // A braking ray never writes its scan record back while a pending brake word is untaken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (scan_wr && hit) |-> (!out_valid_reg || result.ready))
        else $error("brake word overwritten before it was taken");

    // The compare cycle always follows the multiply or holds on a stall.
    a_cmp_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |-> ($past(state_reg) == ST_MUL || $past(state_reg) == ST_CMP))
        else $error("compare cycle entered out of order");

    // Once a scan has braked, the write-back keeps the latch set.
    a_latch_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (scan_wr && scan_reg.braked) |-> mem_wdata[0])
        else $error("brake latch lost on write-back");

endmodule

`default_nettype wire

>>> hdl/ttc_eb_ram.sv
`default_nettype none

module ttc_eb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> test/ttc_emergency_brake_test.sv
`timescale 1ns / 1ps

module ttc_emergency_brake_test;

    import ttc_eb_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 5;
    localparam int SETTLE_CYCLES = 16;
    localparam int LIMIT_NS      = 8_000_000;
    localparam int HOLD_CYCLES   = 300;

    // Word kinds on the item channel.
    localparam logic FUNC_SPEED = 1'b0;
    localparam logic FUNC_RAY   = 1'b1;

    // Fixed-point constants for the cosine table (Q30).
    localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
    localparam longint unsigned UNIT_Q30         = 64'd1073741824;
    localparam longint unsigned HALF_LSB_Q30     = 64'd536870912;

    typedef struct packed {
        logic [RAY_W-1:0]   ray_index;
        logic [ALONG_W-1:0] along_speed;
        logic               drive_speed;
    } brake_word_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    ttc_eb_item_if   item_ch ();
    ttc_eb_result_if brake_ch ();

    ttc_emergency_brake u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (brake_ch)
    );

    // Mirror of the block's registers and scan state.
    logic [ANGLE_W-1:0]        cfg_start = ANGLE_START_RST;
    logic [STEP_W-1:0]         cfg_step  = ANGLE_STEP_RST;
    logic [LIMIT_W-1:0]        cfg_limit = TTC_LIMIT_RST;
    logic signed [SPEED_W-1:0] cur_speed = '0;
    logic [ANGLE_W-1:0]        cur_angle = '0;
    logic [RAY_W-1:0]          cur_count = '0;
    logic                      scan_done = 1'b0;

    int          cos_tab [COS_ENTRIES];
    brake_word_t brake_q [$];
    int          mismatch_count   = 0;
    int          words_sent       = 0;
    int          hold_left        = 0;
    bit          gaps_on          = 1'b1;

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Cosine magnitude of entry k, Taylor series to x^14 in Q30, rounded to Q0.15.
    function automatic int cos_q15(int k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        x    = (QUARTER_TURN_Q30 * 64'(k)) / 64'(COS_ENTRIES);
        x2   = (x * x) >> 30;
        term = UNIT_Q30;
        acc  = longint'(UNIT_Q30);
        for (int n = 1; n <= 7; n++)
        begin
            term = (term * x2) / 64'((2 * n - 1) * (2 * n));
            term = term >> 30;
            if ((n % 2) == 1)
            begin
                acc = acc - longint'(term);
            end
            else
            begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0)
        begin
            acc = 0;
        end
        if (acc > longint'(UNIT_Q30))
        begin
            acc = longint'(UNIT_Q30);
        end
        return int'((64'(acc) * 64'd32767 + HALF_LSB_Q30) >> 30);
    endfunction

    // Signed cosine of a binary angle from the quarter-wave table.
    function automatic int signed_cos(logic [ANGLE_W-1:0] ang);
        logic [1:0]  quad;
        logic [13:0] rem;
        int          idx;
        int          mag;
        quad = ang[15:14];
        rem  = ang[13:0];
        if (quad[0])
        begin
            idx = ((16384 - int'(rem)) * COS_ENTRIES) >> 14;
            mag = (idx >= COS_ENTRIES) ? 0 : cos_tab[idx];
        end
        else
        begin
            mag = cos_tab[(int'(rem) * COS_ENTRIES) >> 14];
        end
        return (quad == 2'd1 || quad == 2'd2) ? -mag : mag;
    endfunction

    // Advances the mirrored state by one accepted word and queues any brake word.
    function automatic void predict_word(logic f, logic signed [SPEED_W-1:0] spd,
                                         logic [RANGE_W-1:0] rng_mm, logic first);
        int          prod;
        int          along;
        brake_word_t w;
        if (f == FUNC_SPEED)
        begin
            cur_speed = spd;
            return;
        end
        if (first)
        begin
            cur_angle = cfg_start;
            cur_count = '0;
            scan_done = 1'b0;
        end
        else
        begin
            cur_angle = cur_angle + ANGLE_W'(cfg_step);
            cur_count = cur_count + 1'b1;
        end
        if (scan_done)
        begin
            return;
        end
        prod = cur_speed * signed_cos(cur_angle);
        if (prod <= 0)
        begin
            return;
        end
        along = prod >>> 15;
        if (along == 0)
        begin
            return;
        end
        if ((64'(rng_mm) * 64'd1000) < (64'(cfg_limit) * 64'(along)))
        begin
            scan_done     = 1'b1;
            w.ray_index   = cur_count;
            w.along_speed = along[ALONG_W-1:0];
            w.drive_speed = 1'b0;
            brake_q.push_back(w);
        end
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (!gaps_on)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 98)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [SPEED_W-1:0] random_speed();
        int mag;
        if ($urandom_range(0, 7) == 0)
        begin
            return SPEED_W'($urandom);
        end
        mag = $urandom_range(500, 32767);
        return SPEED_W'(($urandom_range(0, 1) != 0) ? -mag : mag);
    endfunction

    // Ranges lean toward short distances so that scans brake often.
    function automatic logic [RANGE_W-1:0] random_range();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
        begin
            return RANGE_W'($urandom_range(0, 2000));
        end
        if (r < 7)
        begin
            return RANGE_W'($urandom_range(0, 20000));
        end
        return RANGE_W'($urandom);
    endfunction

    // Offers one word until the block takes it, then idles for a random gap.
    task automatic send_word(input logic f, input logic signed [SPEED_W-1:0] spd,
                             input logic [RANGE_W-1:0] rng_mm, input logic first);
        int gap;
        item_ch.valid      <= 1'b1;
        item_ch.func       <= f;
        item_ch.speed_mm_s <= spd;
        item_ch.range_mm   <= rng_mm;
        item_ch.first_ray  <= first;
        do
        begin
            @(posedge clk);
        end
        while (item_ch.ready !== 1'b1);
        words_sent++;
        predict_word(f, spd, rng_mm, first);
        gap = pick_gap();
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Unused fields carry random bits so that the block must ignore them.
    task automatic send_speed(input logic signed [SPEED_W-1:0] spd);
        send_word(FUNC_SPEED, spd, RANGE_W'($urandom), 1'($urandom));
    endtask

    task automatic send_ray(input logic [RANGE_W-1:0] rng_mm, input logic first);
        send_word(FUNC_RAY, SPEED_W'($urandom), rng_mm, first);
    endtask

    // Stops offering words and waits until the block has nothing left in flight.
    task automatic settle_block();
        item_ch.valid <= 1'b0;
        while (brake_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ANGLE_START:  cfg_start = val[ANGLE_W-1:0];
            CFG_ANGLE_STEP:   cfg_step  = val[STEP_W-1:0];
            CFG_TTC_LIMIT_MS: cfg_limit = val[LIMIT_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic program_regs(input logic [ANGLE_W-1:0] start, input logic [STEP_W-1:0] stp,
                                input logic [LIMIT_W-1:0] limit);
        settle_block();
        write_reg(CFG_ANGLE_START, CFG_W'(start));
        write_reg(CFG_ANGLE_STEP, CFG_W'(stp));
        write_reg(CFG_TTC_LIMIT_MS, CFG_W'(limit));
    endtask

    // Extremes of every field, both word kinds and the scan corner cases.
    task automatic test_directed_extremes();
        // Reset register values still apply here.
        send_ray(16'd0, 1'b0);
        send_speed(16'sh8000);
        send_ray(16'd0, 1'b1);
        send_ray(16'd0, 1'b0);
        send_ray(16'hFFFF, 1'b1);
        send_speed(16'sh7FFF);
        send_ray(16'd0, 1'b1);
        program_regs(16'h0000, 12'd0, 14'h3FFF);
        send_ray(16'hFFFF, 1'b1);
        // A speed of one gives a closing speed that truncates to zero.
        send_speed(16'sd1);
        send_ray(16'd0, 1'b1);
        // A zero threshold never brakes.
        program_regs(16'h0000, 12'd0, 14'd0);
        send_speed(16'sh7FFF);
        send_ray(16'd0, 1'b1);
        // Quarter turn gives a zero cosine; later rays cross into the second quadrant.
        program_regs(16'h4000, 12'hFFF, 14'd1);
        send_ray(16'd0, 1'b1);
        send_ray(16'd0, 1'b0);
        send_speed(16'sh8000);
        send_ray(16'd0, 1'b0);
        program_regs(16'h7FFF, 12'hFFF, 14'd10000);
        send_ray(16'd32, 1'b1);
        program_regs(16'h8000, 12'd1, 14'd10000);
        send_ray(16'd0, 1'b1);
        send_ray(16'd0, 1'b0);
    endtask

    // A brake word waits behind a stalled receiver until the next one stalls the input too.
    task automatic test_output_backpressure();
        gaps_on = 1'b0;
        program_regs(16'h0000, 12'd0, 14'd10000);
        send_speed(16'sd20000);
        hold_left = HOLD_CYCLES;
        repeat (16)
        begin
            send_ray(16'd100, 1'b1);
            send_ray(16'd100, 1'b0);
        end
        settle_block();
        gaps_on = 1'b1;
    endtask

    // Random scans under a new register setting per phase.
    task automatic test_random_scans();
        int                 phase;
        int                 first_word;
        int                 phase_start;
        int                 n_rays;
        int                 pick;
        logic [ANGLE_W-1:0] start;
        logic [STEP_W-1:0]  stp;
        logic [LIMIT_W-1:0] limit;
        phase      = 0;
        first_word = words_sent;
        while ((words_sent - first_word) < 340)
        begin
            start = (phase == 0) ? 16'h8000 : (phase == 1) ? 16'h7FFF : ANGLE_W'($urandom);
            if (phase == 0)
            begin
                stp = 12'd0;
            end
            else if (phase == 1)
            begin
                stp = 12'hFFF;
            end
            else
            begin
                stp = ($urandom_range(0, 3) == 0) ? STEP_W'($urandom)
                                                  : STEP_W'($urandom_range(0, 256));
            end
            limit = (phase == 0) ? 14'h3FFF : (phase == 1) ? 14'd1 : (phase == 2) ? 14'd0
                  : LIMIT_W'($urandom_range(1, 10000));
            program_regs(start, stp, limit);
            // One phase runs with both sides flat out.
            gaps_on     = (phase != 3);
            phase_start = words_sent;
            while ((words_sent - phase_start) < 60)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                begin
                    send_speed(random_speed());
                end
                else if (pick == 1)
                begin
                    send_ray(random_range(), 1'b0);
                end
                else
                begin
                    if ($urandom_range(0, 3) != 0)
                    begin
                        send_speed(random_speed());
                    end
                    send_ray(random_range(), 1'b1);
                    n_rays = $urandom_range(0, 12);
                    repeat (n_rays) send_ray(random_range(), 1'b0);
                end
            end
            phase++;
        end
        gaps_on = 1'b1;
    endtask

    // Receiver: random stalls, plus a long hold-off when a test requests one.
    initial
    begin : brake_sink
        int stall_left;
        stall_left = 0;
        brake_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                brake_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                brake_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                brake_ch.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // Each accepted brake word is checked against the oldest expected one.
    always @(posedge clk)
    begin : check_brakes
        brake_word_t want;
        if (rst_n === 1'b1 && brake_ch.valid === 1'b1 && brake_ch.ready === 1'b1)
        begin
            if (brake_q.size() == 0)
            begin
                $display("%0t: brake word with none expected: ray_index %0d along_speed %0d",
                         $time, brake_ch.ray_index, brake_ch.along_speed);
                mismatch_count++;
            end
            else
            begin
                want = brake_q.pop_front();
                if (brake_ch.ray_index !== want.ray_index)
                begin
                    $display("%0t: ray_index expected %0d, got %0d",
                             $time, want.ray_index, brake_ch.ray_index);
                    mismatch_count++;
                end
                if (brake_ch.along_speed !== want.along_speed)
                begin
                    $display("%0t: along_speed expected %0d, got %0d",
                             $time, want.along_speed, brake_ch.along_speed);
                    mismatch_count++;
                end
                if (brake_ch.drive_speed !== want.drive_speed)
                begin
                    $display("%0t: drive_speed expected %0d, got %0d",
                             $time, want.drive_speed, brake_ch.drive_speed);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        #LIMIT_NS;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        for (int k = 0; k < COS_ENTRIES; k++)
        begin
            cos_tab[k] = cos_q15(k);
        end
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= '0;
        cfg_data           <= '0;
        item_ch.valid      <= 1'b0;
        item_ch.func       <= FUNC_SPEED;
        item_ch.speed_mm_s <= '0;
        item_ch.range_mm   <= '0;
        item_ch.first_ray  <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_extremes();
        test_output_backpressure();
        test_random_scans();

        settle_block();
        if (mismatch_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
